// ===== rtl/ras_pkg.sv =====
// Shared types and constants for the room allocation scheduler.
package ras_pkg;

   localparam int MAX_ROOMS = 16;
   localparam int TIME_BITS = 40;

   localparam int ROOM_BITS = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
   localparam int COUNT_W   = 16;
   localparam int SUM_W     = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;

   localparam logic [SUM_W-1:0] TIME_MAX = SUM_W'({TIME_BITS{1'b1}});
   localparam logic [4:0] ROOM_COUNT_RESET = 5'd16;

   typedef struct packed {
      logic [31:0] start_time;
      logic [31:0] end_time;
      logic        last_request;
   } req_type;

   typedef struct packed {
      logic [3:0]  assigned_room;
      logic [39:0] actual_start;
      logic [3:0]  top_room;
      logic [15:0] top_count;
      logic        batch_done;
   } rsp_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] busy_until;
      logic [COUNT_W-1:0]   booking_count;
   } entry_type;

   function automatic logic [3:0] room_out(input logic [ROOM_BITS-1:0] idx);
      logic [ROOM_BITS+3:0] wide;
      wide = (ROOM_BITS + 4)'(idx);
      return wide[3:0];
   endfunction

   function automatic logic [39:0] time_out(input logic [TIME_BITS-1:0] t);
      logic [TIME_BITS+39:0] wide;
      wide = (TIME_BITS + 40)'(t);
      return wide[39:0];
   endfunction

endpackage

// ===== rtl/ras_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ras_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/room_allocation_scheduler.sv =====
// Room allocation scheduler top level: scan of room entries, pick, write-back.
// Steps: scan of one room entry a cycle over N = active room count (1..16),
// resolve, write-back, result; the next request is taken once back in idle.
// A new request is taken while the previous result still waits on rsp.
// Reset (synchronous): all rooms free, counts zero, room count 16; entries are
// invalidated by per-room valid bits, so no clearing pass is needed.
module room_allocation_scheduler (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ras_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output ras_pkg::rsp_type rsp_data,
   input  logic            csr_wr_en,
   input  logic [4:0]      csr_wr_data
);
   import ras_pkg::*;

   localparam int NB_W = (ROOM_BITS + 1 > 5) ? ROOM_BITS + 1 : 5;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_RESOLVE,
      S_WRITE,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [4:0]           room_count_ff, room_count_in;
   logic [MAX_ROOMS-1:0] valid_ff, valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   // request word
   logic [31:0]          start_ff, start_in;
   logic [31:0]          dur_ff, dur_in;
   logic                 last_ff, last_in;
   logic [ROOM_BITS-1:0] last_idx_ff, last_idx_in;

   // scan control
   logic [ROOM_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic                 issue_done_ff, issue_done_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [ROOM_BITS-1:0] rd_idx_ff, rd_idx_in;

   // scan accumulators
   logic                 found_ff, found_in;
   logic [ROOM_BITS-1:0] fidx_ff, fidx_in;
   logic [COUNT_W-1:0]   fcnt_ff, fcnt_in;
   logic [TIME_BITS-1:0] minb_ff, minb_in;
   logic [ROOM_BITS-1:0] midx_ff, midx_in;
   logic [COUNT_W-1:0]   mcnt_ff, mcnt_in;
   logic [COUNT_W-1:0]   maxc_ff, maxc_in;
   logic [ROOM_BITS-1:0] maxi_ff, maxi_in;

   // resolved booking
   logic [ROOM_BITS-1:0] room_ff, room_in;
   logic [TIME_BITS-1:0] begin_ff, begin_in;
   logic [COUNT_W-1:0]   cnt_new_ff, cnt_new_in;
   logic [ROOM_BITS-1:0] top_ff, top_in;
   logic [COUNT_W-1:0]   topc_ff, topc_in;

   // RAM port
   logic                 ram_wr_en;
   entry_type            ram_wr_entry;
   logic                 ram_rd_en;
   logic [$bits(entry_type)-1:0] ram_rd_raw;
   entry_type            rd_entry;

   // combinational helpers
   logic [NB_W-1:0]      n_ext;
   logic [NB_W-1:0]      n_m1;
   logic [SUM_W-1:0]     s_ext;
   logic [SUM_W-1:0]     s_masked;
   logic [SUM_W-1:0]     fin_wide;
   logic [TIME_BITS-1:0] fin;
   logic [ROOM_BITS-1:0] r_sel;
   logic [COUNT_W-1:0]   c_old;
   logic [COUNT_W-1:0]   c_new;
   logic                 rsp_load;

   ras_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_ROOMS)
   ) u_room_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (room_ff),
      .wr_data (ram_wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_raw)
   );

   // entries never written since the last clear read as free with no bookings
   always_comb begin
      rd_entry = entry_type'(ram_rd_raw);
      if (!valid_ff[rd_idx_ff]) begin
         rd_entry = '0;
      end
   end

   always_comb begin
      n_ext = NB_W'(room_count_ff);
      if (n_ext == '0) begin
         n_ext = NB_W'(1);
      end else if (n_ext > NB_W'(MAX_ROOMS)) begin
         n_ext = NB_W'(MAX_ROOMS);
      end
      n_m1 = n_ext - NB_W'(1);
   end

   always_comb begin
      s_ext    = SUM_W'(start_ff);
      s_masked = s_ext & TIME_MAX;
      fin_wide = SUM_W'(begin_ff) + SUM_W'(dur_ff);
      fin      = (fin_wide > TIME_MAX) ? TIME_MAX[TIME_BITS-1:0] : fin_wide[TIME_BITS-1:0];
      r_sel    = found_ff ? fidx_ff : midx_ff;
      c_old    = found_ff ? fcnt_ff : mcnt_ff;
      c_new    = (c_old == '1) ? c_old : c_old + COUNT_W'(1);
   end

   assign ram_rd_en    = (state_ff == S_SCAN) && !issue_done_ff;
   assign ram_wr_en    = (state_ff == S_WRITE);
   assign ram_wr_entry = '{busy_until: fin, booking_count: cnt_new_ff};
   assign rsp_load     = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      room_count_in = csr_wr_en ? csr_wr_data : room_count_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      start_in      = start_ff;
      dur_in        = dur_ff;
      last_in       = last_ff;
      last_idx_in   = last_idx_ff;
      rd_ptr_in     = rd_ptr_ff;
      issue_done_in = issue_done_ff;
      rd_vld_in     = ram_rd_en;
      rd_idx_in     = rd_ptr_ff;
      found_in      = found_ff;
      fidx_in       = fidx_ff;
      fcnt_in       = fcnt_ff;
      minb_in       = minb_ff;
      midx_in       = midx_ff;
      mcnt_in       = mcnt_ff;
      maxc_in       = maxc_ff;
      maxi_in       = maxi_ff;
      room_in       = room_ff;
      begin_in      = begin_ff;
      cnt_new_in    = cnt_new_ff;
      top_in        = top_ff;
      topc_in       = topc_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               start_in      = req_data.start_time;
               dur_in        = (req_data.end_time > req_data.start_time) ?
                               req_data.end_time - req_data.start_time : '0;
               last_in       = req_data.last_request;
               last_idx_in   = n_m1[ROOM_BITS-1:0];
               rd_ptr_in     = '0;
               issue_done_in = 1'b0;
               found_in      = 1'b0;
               maxc_in       = '0;
               maxi_in       = '0;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            if (!issue_done_ff) begin
               if (rd_ptr_ff == last_idx_ff) begin
                  issue_done_in = 1'b1;
               end else begin
                  rd_ptr_in = rd_ptr_ff + ROOM_BITS'(1);
               end
            end
            if (rd_vld_ff) begin
               if (!found_ff && (SUM_W'(rd_entry.busy_until) <= s_ext)) begin
                  found_in = 1'b1;
                  fidx_in  = rd_idx_ff;
                  fcnt_in  = rd_entry.booking_count;
               end
               if ((rd_idx_ff == '0) || (rd_entry.busy_until < minb_ff)) begin
                  minb_in = rd_entry.busy_until;
                  midx_in = rd_idx_ff;
                  mcnt_in = rd_entry.booking_count;
               end
               if (rd_entry.booking_count > maxc_ff) begin
                  maxc_in = rd_entry.booking_count;
                  maxi_in = rd_idx_ff;
               end
               if (rd_idx_ff == last_idx_ff) begin
                  state_in = S_RESOLVE;
               end
            end
         end
         S_RESOLVE: begin
            room_in    = r_sel;
            begin_in   = found_ff ? s_masked[TIME_BITS-1:0] : minb_ff;
            cnt_new_in = c_new;
            // top after the bump: only the chosen room's count moved
            if (r_sel == maxi_ff) begin
               top_in  = maxi_ff;
               topc_in = c_new;
            end else if (c_new > maxc_ff) begin
               top_in  = r_sel;
               topc_in = c_new;
            end else if (c_new == maxc_ff) begin
               top_in  = (r_sel < maxi_ff) ? r_sel : maxi_ff;
               topc_in = maxc_ff;
            end else begin
               top_in  = maxi_ff;
               topc_in = maxc_ff;
            end
            state_in = S_WRITE;
         end
         S_WRITE: begin
            valid_in[room_ff] = 1'b1;
            if (last_ff) begin
               valid_in = '0;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.assigned_room = room_out(room_ff);
               rsp_data_in.actual_start  = time_out(begin_ff);
               rsp_data_in.top_room      = room_out(top_ff);
               rsp_data_in.top_count     = topc_ff;
               rsp_data_in.batch_done    = last_ff;
               state_in                  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         room_count_ff <= ROOM_COUNT_RESET;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         rd_vld_ff     <= 1'b0;
         issue_done_ff <= 1'b1;
      end else begin
         state_ff      <= state_in;
         room_count_ff <= room_count_in;
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         rd_vld_ff     <= rd_vld_in;
         issue_done_ff <= issue_done_in;
      end
      rsp_data_ff <= rsp_data_in;
      start_ff    <= start_in;
      dur_ff      <= dur_in;
      last_ff     <= last_in;
      last_idx_ff <= last_idx_in;
      rd_ptr_ff   <= rd_ptr_in;
      rd_idx_ff   <= rd_idx_in;
      found_ff    <= found_in;
      fidx_ff     <= fidx_in;
      fcnt_ff     <= fcnt_in;
      minb_ff     <= minb_in;
      midx_ff     <= midx_in;
      mcnt_ff     <= mcnt_in;
      maxc_ff     <= maxc_in;
      maxi_ff     <= maxi_in;
      room_ff     <= room_in;
      begin_ff    <= begin_in;
      cnt_new_ff  <= cnt_new_in;
      top_ff      <= top_in;
      topc_ff     <= topc_in;
   end

endmodule

// ===== test/tb_room_allocation_scheduler.sv =====
// Self-checking testbench for the room allocation scheduler: booking requests against a predictor.
module tb_room_allocation_scheduler;
   import ras_pkg::*;

   localparam logic [39:0] TIME_LIMIT = '1;
   localparam logic [15:0] COUNT_LIMIT = '1;
   localparam int RANDOM_WORDS = 1170;

   class room_ledger;
      logic [39:0] busy_until[MAX_ROOMS];
      logic [15:0] bookings[MAX_ROOMS];
      logic [4:0]  room_cfg;
      rsp_type     due_results[$];
      int          errors;

      function new();
         clear_rooms();
         room_cfg = ROOM_COUNT_RESET;
         errors = 0;
      endfunction

      function void clear_rooms();
         for (int i = 0; i < MAX_ROOMS; i++) begin
            busy_until[i] = '0;
            bookings[i] = '0;
         end
      endfunction

      function void set_rooms(input logic [4:0] value);
         room_cfg = value;
      endfunction

      // Book one request and queue the result it should give.
      function void take_booking(input req_type req);
         int          n, room, top;
         bit          found;
         logic [31:0] dur;
         logic [39:0] start_at, fin;
         logic [15:0] top_cnt;
         rsp_type     want;
         n = (room_cfg == 0) ? 1 : ((room_cfg > MAX_ROOMS) ? MAX_ROOMS : int'(room_cfg));
         dur = (req.end_time > req.start_time) ? req.end_time - req.start_time : '0;
         found = 0;
         room = 0;
         for (int i = 0; i < n; i++) begin
            if (!found && busy_until[i] <= {8'b0, req.start_time}) begin
               room = i;
               found = 1;
            end
         end
         if (found) begin
            start_at = {8'b0, req.start_time};
         end else begin
            // nothing free: earliest finisher, lower index on ties
            for (int i = 1; i < n; i++)
               if (busy_until[i] < busy_until[room]) room = i;
            start_at = busy_until[room];
         end
         if (start_at > TIME_LIMIT - {8'b0, dur}) fin = TIME_LIMIT;
         else fin = start_at + {8'b0, dur};
         busy_until[room] = fin;
         if (bookings[room] != COUNT_LIMIT) bookings[room] = bookings[room] + 1'b1;
         top = 0;
         top_cnt = '0;
         for (int i = 0; i < n; i++) begin
            if (bookings[i] > top_cnt) begin
               top_cnt = bookings[i];
               top = i;
            end
         end
         want.assigned_room = 4'(room);
         want.actual_start = start_at;
         want.top_room = 4'(top);
         want.top_count = top_cnt;
         want.batch_done = req.last_request;
         due_results.push_back(want);
         if (req.last_request) clear_rooms();
      endfunction

      task report(input string msg);
         errors++;
         if (errors <= 40) $display("mismatch at %0t: %s", $realtime, msg);
      endtask

      task match_result(input rsp_type got);
         rsp_type want;
         if (due_results.size() == 0) begin
            report($sformatf("unexpected result %h", got));
         end else begin
            want = due_results.pop_front();
            if (got.assigned_room !== want.assigned_room)
               report($sformatf("assigned_room %0d, want %0d",
                                got.assigned_room, want.assigned_room));
            if (got.actual_start !== want.actual_start)
               report($sformatf("actual_start %h, want %h",
                                got.actual_start, want.actual_start));
            if (got.top_room !== want.top_room)
               report($sformatf("top_room %0d, want %0d", got.top_room, want.top_room));
            if (got.top_count !== want.top_count)
               report($sformatf("top_count %0d, want %0d", got.top_count, want.top_count));
            if (got.batch_done !== want.batch_done)
               report($sformatf("batch_done %b, want %b", got.batch_done, want.batch_done));
         end
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_wr_en = 1'b0;
   logic [4:0] csr_wr_data = '0;

   room_ledger book = new();
   bit idle_on = 1'b1;

   room_allocation_scheduler dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver: stalls in short bursts
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 4);
         end
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready) book.match_result(rsp_data);

   task offer_booking(input logic [31:0] s, input logic [31:0] e, input logic is_last);
      req_type word;
      int gap;
      word.start_time = s;
      word.end_time = e;
      word.last_request = is_last;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 4);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      book.take_booking(word);
   endtask

   task drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (book.due_results.size() != 0) @(negedge clock);
   endtask

   task set_room_count(input logic [4:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      book.set_rooms(value);
   endtask

   task random_batches(input int total);
      int          made, len, pick, scale;
      logic [31:0] dur_cap, step_cap, s, s_item, e, dur, step;
      logic [32:0] sum;
      logic        is_last;
      made = 0;
      while (made < total) begin
         drain_results();
         case ($urandom_range(0, 9))
            0: set_room_count(5'($urandom_range(0, 31)));
            1: set_room_count(5'd1);
            2: set_room_count(5'd16);
            default: set_room_count(5'($urandom_range(1, 16)));
         endcase
         len = $urandom_range(1, 40);
         scale = $urandom_range(0, 3);
         case (scale)
            0: dur_cap = 32'd20;
            1: dur_cap = 32'd2000;
            2: dur_cap = 32'h000F_FFFF;
            default: dur_cap = '1;
         endcase
         step_cap = dur_cap >> $urandom_range(1, 6);
         case ($urandom_range(0, 2))
            0: s = '0;
            1: s = $urandom_range(0, 5000);
            default: s = $urandom;
         endcase
         for (int k = 0; k < len && made < total; k++) begin
            if (made >= total - 200) idle_on = 1'b0;
            if (k != 0 && $urandom_range(0, 39) == 0) begin
               // room count changed with the batch still open
               drain_results();
               set_room_count(5'($urandom_range(0, 31)));
            end
            step = $urandom_range(0, step_cap);
            sum = {1'b0, s} + {1'b0, step};
            s = sum[32] ? '1 : sum[31:0];
            s_item = s;
            dur = $urandom_range(1, dur_cap);
            pick = $urandom_range(0, 19);
            if (pick == 2) s_item = $urandom_range(0, s);
            if (pick == 0) begin
               e = $urandom;
            end else if (pick == 1) begin
               e = $urandom_range(0, s_item);
            end else begin
               sum = {1'b0, s_item} + {1'b0, dur};
               e = sum[32] ? '1 : sum[31:0];
            end
            is_last = (k == len - 1) || ($urandom_range(0, 63) == 0);
            offer_booking(s_item, e, is_last);
            made++;
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset room count of 16; zero and negative durations, extremes
      offer_booking(32'd0, 32'd0, 1'b0);
      offer_booking(32'd10, 32'd5, 1'b0);
      offer_booking(32'd10, 32'd100, 1'b0);
      offer_booking(32'd20, 32'd50, 1'b0);
      offer_booking(32'd30, 32'd40, 1'b0);
      offer_booking(32'd35, 32'hFFFF_FFFF, 1'b0);
      offer_booking(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      drain_results();
      set_room_count(5'd2);
      // waiting for the earliest room, start order broken
      offer_booking(32'd0, 32'd100, 1'b0);
      offer_booking(32'd0, 32'd50, 1'b0);
      offer_booking(32'd0, 32'd10, 1'b0);
      offer_booking(32'd5, 32'd1000, 1'b0);
      offer_booking(32'd200, 32'd300, 1'b0);
      offer_booking(32'd100, 32'd150, 1'b0);
      offer_booking(32'd0, 32'd10, 1'b1);
      // tie between rooms freeing at the same time
      offer_booking(32'd0, 32'd10, 1'b0);
      offer_booking(32'd0, 32'd10, 1'b0);
      offer_booking(32'd0, 32'd5, 1'b0);
      drain_results();
      set_room_count(5'd1);
      offer_booking(32'd0, 32'd1, 1'b0);
      drain_results();
      set_room_count(5'd0);
      offer_booking(32'd2, 32'd3, 1'b0);
      drain_results();
      set_room_count(5'd31);
      offer_booking(32'd4, 32'd4, 1'b1);
      drain_results();
      set_room_count(5'd17);
      offer_booking(32'd0, 32'd1, 1'b1);

      // one room, longest bookings back to back: busy-until saturates
      drain_results();
      set_room_count(5'd1);
      for (int k = 0; k < 260; k++) offer_booking(32'd0, 32'hFFFF_FFFF, 1'(k == 259));

      random_batches(RANDOM_WORDS);

      drain_results();
      repeat (24) @(posedge clock);
      if (book.due_results.size() != 0)
         book.report($sformatf("%0d results never came", book.due_results.size()));
      if (book.errors == 0) begin
         $display("PASS room_allocation_scheduler");
      end else begin
         $display("FAIL room_allocation_scheduler");
      end
      $finish;
   end

   initial begin
      #25_000_000;
      $display("FAIL room_allocation_scheduler");
      $finish;
   end

endmodule
